### design/nts_pkg.sv
// Shared types and constants for the nearest texture sampler with repeat wrap.
package nts_pkg;

  localparam int COORD_W = 24;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int TEXEL_W = 3 * CHAN_W;
  localparam int SIZE_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

  typedef struct packed {
    logic                       opcode;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
    logic [COL_W-1:0]           write_column;
    logic [ROW_W-1:0]           write_row;
    logic [CHAN_W-1:0]          write_red;
    logic [CHAN_W-1:0]          write_green;
    logic [CHAN_W-1:0]          write_blue;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] sample_red;
    logic [CHAN_W-1:0] sample_green;
    logic [CHAN_W-1:0] sample_blue;
  } out_word_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_READ,
    ST_RESULT
  } state_t;

endpackage

### design/nts_wrap_scale.sv
// Repeat wrap of u and v and scaling of the fractions to a column and row index.
module nts_wrap_scale
  import nts_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  input  logic [SIZE_W-1:0]         width_sz,
  input  logic [SIZE_W-1:0]         height_sz,
  output logic [SIZE_W-1:0]         col_idx_r,
  output logic [SIZE_W-1:0]         row_idx_r
);

  localparam int PW = FRACTION_BITS + SIZE_W;

  logic [FRACTION_BITS-1:0] frac_u_r;
  logic [FRACTION_BITS-1:0] frac_v_r;
  logic [PW-1:0]            prod_u;
  logic [PW-1:0]            prod_v;

  always_ff @(posedge clk) begin
    if (load) begin
      frac_u_r <= coord_u[FRACTION_BITS-1:0];
      frac_v_r <= coord_v[FRACTION_BITS-1:0];
    end
  end

  assign prod_u = PW'(frac_u_r) * PW'(width_sz);
  assign prod_v = PW'(frac_v_r) * PW'(height_sz);

  always_ff @(posedge clk) begin
    col_idx_r <= prod_u[PW-1:FRACTION_BITS];
    row_idx_r <= prod_v[PW-1:FRACTION_BITS];
  end

endmodule

### design/nts_texel_mem.sv
// Texel store with separate write and read addresses, one write and one registered read per cycle.
module nts_texel_mem
  import nts_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [TEXEL_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [TEXEL_W-1:0] rdata_r
);

  logic [TEXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### design/nearest_texture_sampler_wrap_top.sv
// Top level: config registers, sequencer, texel store and output register.
// A texel write is taken while the sequencer is idle; writes can arrive every cycle while no sample is in progress.
// A sample goes through the scale (wrap/multiply), read (address and store read) and result
// states before its word shows on out_valid; no new word is taken until it is back in idle.
// The sequencer sets the sample rate: it stalls input until a sample has left the result state.
// Reset (rst_n low, synchronous) sets width and height to 128 and empties the
// output register; store contents stay undefined until written, with no clearing pass.
module nearest_texture_sampler_wrap_top
  import nts_pkg::*;
#(
  parameter int MAX_COLUMNS   = 128,
  parameter int MAX_ROWS      = 128,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLUMNS);
  localparam logic [SIZE_W-1:0] MAXC = (MAX_COLUMNS > 255) ? 8'd255 : SIZE_W'(MAX_COLUMNS);
  localparam logic [SIZE_W-1:0] MAXR = (MAX_ROWS > 255) ? 8'd255 : SIZE_W'(MAX_ROWS);

  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;
  logic [SIZE_W-1:0]  width_sz;
  logic [SIZE_W-1:0]  height_sz;
  logic               cfg_wr;
  state_t             state_r;
  state_t             state_nxt;
  logic               accept;
  logic               wr_in_range;
  logic               coord_load;
  logic               out_load;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [TEXEL_W-1:0] wdata;
  logic [TEXEL_W-1:0] rdata;
  logic [SIZE_W-1:0]  col_idx;
  logic [SIZE_W-1:0]  row_idx;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_word_t          out_data_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[SIZE_W-1:0];
      end else begin
        height_r <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? PDATA_W'(height_r) : PDATA_W'(width_r);

  always_comb begin
    if (width_r == '0) begin
      width_sz = 8'd1;
    end else if (32'(width_r) > MAX_COLUMNS) begin
      width_sz = MAXC;
    end else begin
      width_sz = width_r;
    end
    if (height_r == '0) begin
      height_sz = 8'd1;
    end else if (32'(height_r) > MAX_ROWS) begin
      height_sz = MAXR;
    end else begin
      height_sz = height_r;
    end
  end

  // sequencer
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_in_range = (32'(in_data.write_column) < MAX_COLUMNS) &&
                       (32'(in_data.write_row) < MAX_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.opcode == OP_SAMPLE)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:  state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    coord_load    = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        coord_load    = accept && (in_data.opcode == OP_SAMPLE);
        mem_ctl.wr_en = accept && (in_data.opcode == OP_WRITE) && wr_in_range;
      end
      ST_SCALE:  ;
      ST_READ:   mem_ctl.rd_en = 1'b1;
      ST_RESULT: out_load = !out_valid_r || !out_stall;
      default:   ;
    endcase
  end

  nts_wrap_scale #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_wrap_scale (
    .clk      (clk),
    .load     (coord_load),
    .coord_u  (in_data.coord_u),
    .coord_v  (in_data.coord_v),
    .width_sz (width_sz),
    .height_sz(height_sz),
    .col_idx_r(col_idx),
    .row_idx_r(row_idx)
  );

  assign waddr = AW'(AW'(in_data.write_row) * COLS_A) + AW'(in_data.write_column);
  assign wdata = {in_data.write_red, in_data.write_green, in_data.write_blue};
  assign raddr = AW'(AW'(row_idx) * COLS_A) + AW'(col_idx);

  nts_texel_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_texel_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata_r(rdata)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sample_enters_scale: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.opcode == OP_SAMPLE) |=> state_r == ST_SCALE)
    else $error("sample word did not start the scale step");

  a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_RESULT)
    else $error("store read not followed by result step");

  a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not moved to output register");

  a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESULT)
    else $error("output word appeared without a store read");

endmodule

### tb/nearest_texture_sampler_wrap_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest texture sampler with repeat wrap.
module nearest_texture_sampler_wrap_top_tb;
  import nts_pkg::*;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS_TB  = 128;
  localparam int FRAC_BITS    = 16;
  localparam int STORE_DEPTH  = MAX_COLS * MAX_ROWS_TB;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predictor state
  logic [TEXEL_W-1:0] texels [STORE_DEPTH];
  bit                 texel_written [STORE_DEPTH];
  logic [SIZE_W-1:0]  width_reg = SIZE_RESET;
  logic [SIZE_W-1:0]  height_reg = SIZE_RESET;
  out_word_t          pending_samples [$];

  int mismatches = 0;
  int samples_checked = 0;
  int texels_loaded = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  nearest_texture_sampler_wrap_top #(
    .MAX_COLUMNS  (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS_TB),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d samples outstanding", $time, pending_samples.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        $display("%0t unexpected sample word: expected none, got r=%02h g=%02h b=%02h",
                 $time, out_data.sample_red, out_data.sample_green, out_data.sample_blue);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (out_data.sample_red !== want.sample_red ||
            out_data.sample_green !== want.sample_green ||
            out_data.sample_blue !== want.sample_blue) begin
          mismatches++;
          $display("%0t sample mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                   $time, want.sample_red, want.sample_green, want.sample_blue,
                   out_data.sample_red, out_data.sample_green, out_data.sample_blue);
        end
      end
    end
  end

  function automatic int fit_size(logic [SIZE_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic int wrap_to(logic [COORD_W-1:0] coord, int size);
    return (int'(coord[FRAC_BITS-1:0]) * size) >> FRAC_BITS;
  endfunction

  function automatic int texel_addr(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    return wrap_to(v, fit_size(height_reg, MAX_ROWS_TB)) * MAX_COLS +
           wrap_to(u, fit_size(width_reg, MAX_COLS));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.opcode       = 1'($urandom);
    w.coord_u      = COORD_W'($urandom);
    w.coord_v      = COORD_W'($urandom);
    w.write_column = COL_W'($urandom);
    w.write_row    = ROW_W'($urandom);
    w.write_red    = CHAN_W'($urandom);
    w.write_green  = CHAN_W'($urandom);
    w.write_blue   = CHAN_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t texel_word(int col, int row);
    in_word_t w;
    w = random_word();
    w.opcode       = OP_WRITE;
    w.write_column = COL_W'(col);
    w.write_row    = ROW_W'(row);
    return w;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(9))
      0: c[FRAC_BITS-1:0] = '1;
      1: c[FRAC_BITS-1:0] = '0;
      default: ;
    endcase
    return c[COORD_W-1:0];
  endfunction

  // Update the texel store or predict the sampled texel for an accepted word
  function automatic void take_word(in_word_t w);
    int a;
    if (w.opcode == OP_WRITE) begin
      a = int'(w.write_row) * MAX_COLS + int'(w.write_column);
      texels[a] = {w.write_red, w.write_green, w.write_blue};
      texel_written[a] = 1'b1;
      texels_loaded++;
    end else begin
      pending_samples.insert(pending_samples.size(),
                             out_word_t'(texels[texel_addr(w.coord_u, w.coord_v)]));
    end
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= random_word();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_word(w);
  endtask

  // Samples only texels already loaded: an unloaded target gets a write first
  task automatic send_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    in_word_t w;
    int a;
    a = texel_addr(u, v);
    if (!texel_written[a]) send_word(texel_word(a % MAX_COLS, a / MAX_COLS));
    w = random_word();
    w.opcode  = OP_SAMPLE;
    w.coord_u = u;
    w.coord_v = v;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(logic idx, logic wr, logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic idx, logic [SIZE_W-1:0] want);
    logic [PDATA_W-1:0] got;
    cfg_access(idx, 1'b0, '0, got);
    if (got[SIZE_W-1:0] !== want) begin
      mismatches++;
      $display("%0t register %0d readback: expected %02h, got %02h",
               $time, idx, want, got[SIZE_W-1:0]);
    end
  endtask

  task automatic configure(logic [SIZE_W-1:0] w_raw, logic [SIZE_W-1:0] h_raw);
    logic [PDATA_W-1:0] unused;
    cfg_access(REG_WIDTH, 1'b1, {24'($urandom), w_raw}, unused);
    width_reg = w_raw;
    cfg_access(REG_HEIGHT, 1'b1, {24'($urandom), h_raw}, unused);
    height_reg = h_raw;
    check_reg(REG_WIDTH, w_raw);
    check_reg(REG_HEIGHT, h_raw);
  endtask

  task automatic test_reset_values();
    check_reg(REG_WIDTH, SIZE_RESET);
    check_reg(REG_HEIGHT, SIZE_RESET);
  endtask

  task automatic test_directed_edges();
    in_word_t w;
    w = texel_word(0, 0);
    {w.write_red, w.write_green, w.write_blue} = '0;
    w.coord_u = 24'h7FFFFF;
    w.coord_v = 24'h800000;
    send_word(w);
    w = texel_word(127, 127);
    {w.write_red, w.write_green, w.write_blue} = '1;
    w.coord_u = 24'h800000;
    w.coord_v = 24'h7FFFFF;
    send_word(w);
    w = texel_word(127, 0);
    {w.write_red, w.write_green, w.write_blue} = 24'hAA55AA;
    send_word(w);
    w = texel_word(0, 127);
    {w.write_red, w.write_green, w.write_blue} = 24'h55AA55;
    send_word(w);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'h00FFFF, 24'h00FFFF);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h7F0000, 24'h810000);
    // overwrite then read back the same texel
    w = texel_word(0, 0);
    {w.write_red, w.write_green, w.write_blue} = 24'h123456;
    send_word(w);
    w = random_word();
    w.opcode = OP_SAMPLE;
    w.coord_u = 24'h000000;
    w.coord_v = 24'hFF0000;
    {w.write_column, w.write_row, w.write_red, w.write_green, w.write_blue} = '1;
    send_word(w);
    send_sample(24'h008000, 24'h00C000);
    drain();
  endtask

  task automatic test_size_limits();
    configure(8'd0, 8'd255);
    send_sample(24'h00FFFF, 24'h00FFFF);
    send_sample(24'h7FFFFF, 24'h800000);
    drain();
    configure(8'd200, 8'd1);
    send_sample(24'h00FFFF, 24'h12FFFF);
    send_sample(24'hFF0001, 24'h000000);
    drain();
    configure(8'd1, 8'd128);
    send_sample(rand_coord(), 24'h00FFFF);
    send_sample(rand_coord(), rand_coord());
    drain();
  endtask

  task automatic test_random_traffic(int items, logic [SIZE_W-1:0] w_raw,
                                     logic [SIZE_W-1:0] h_raw, int s_pct, int r_pct);
    int col;
    int row;
    configure(w_raw, h_raw);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (items) begin
      if ($urandom_range(99) < 45) begin
        if ($urandom_range(99) < 80) begin
          col = $urandom_range(fit_size(width_reg, MAX_COLS) - 1);
          row = $urandom_range(fit_size(height_reg, MAX_ROWS_TB) - 1);
        end else begin
          col = $urandom_range(MAX_COLS - 1);
          row = $urandom_range(MAX_ROWS_TB - 1);
        end
        send_word(texel_word(col, row));
      end else begin
        send_sample(rand_coord(), rand_coord());
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    configure(8'(1 + $urandom_range(15)), 8'(1 + $urandom_range(15)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    repeat (40) send_sample(rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_edges();
    test_size_limits();
    test_random_traffic(150, 8'(1 + $urandom_range(15)), 8'(1 + $urandom_range(15)), 17, 56);
    test_random_traffic(150, 8'd128, 8'd1, 56, 17);
    test_random_traffic(150, 8'd0, 8'd255, 0, 0);
    test_random_traffic(150, 8'(1 + $urandom_range(127)), 8'd128, 0, 0);
    test_backpressure();
    $display("Covered %0d texel writes and %0d checked samples over sizes 1 to 128,",
             texels_loaded, samples_checked);
    $display("zero and oversize size settings, random idling and a long output hold-off.");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
